>>> rtl/tls_pkg.sv
// shared types, constants and helper functions for the trigraph and line splice block
// no dependencies

package tls_pkg;

    localparam int MAX_RESULTS = 5;
    localparam int CNT_W       = 3;

    localparam logic [7:0] QMARK   = 8'h3F;
    localparam logic [7:0] BSLASH  = 8'h5C;
    localparam logic [7:0] NEWLINE = 8'h0A;

    // one whole character, first byte in the low bits
    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  len;
    } chr_t;

    // one result beat, last is added by the result buffer
    typedef struct packed {
        chr_t chr;
        logic end_f;
        logic err_f;
    } result_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] to;
    } tri_hit_t;

    // one push into the splice window
    typedef struct packed {
        chr_t       w0;
        chr_t       w1;
        logic [1:0] cnt;
        logic       emit;
        chr_t       out;
    } splice_step_t;

    function automatic result_t mk_res(chr_t c, logic e, logic r);
        result_t res;
        res.chr   = c;
        res.end_f = e;
        res.err_f = r;
        return res;
    endfunction

    // clamp the length to four and clear bytes past it
    function automatic chr_t norm_char(logic [31:0] bytes, logic [2:0] len);
        chr_t c;
        c.len   = (len > 3'd4) ? 3'd4 : len;
        c.bytes = bytes;
        case (c.len)
            3'd0:    c.bytes = 32'd0;
            3'd1:    c.bytes = {24'd0, bytes[7:0]};
            3'd2:    c.bytes = {16'd0, bytes[15:0]};
            3'd3:    c.bytes = {8'd0, bytes[23:0]};
            default: c.bytes = bytes;
        endcase
        return c;
    endfunction

    // third character of a ??x trigraph to its replacement
    function automatic tri_hit_t tri_map(logic [7:0] b);
        tri_hit_t t;
        t.hit = 1'b1;
        t.to  = 8'h00;
        case (b)
            8'h3D:   t.to = 8'h23;
            8'h28:   t.to = 8'h5B;
            8'h2F:   t.to = 8'h5C;
            8'h29:   t.to = 8'h5D;
            8'h27:   t.to = 8'h5E;
            8'h3C:   t.to = 8'h7B;
            8'h21:   t.to = 8'h7C;
            8'h3E:   t.to = 8'h7D;
            8'h2D:   t.to = 8'h7E;
            default: t.hit = 1'b0;
        endcase
        return t;
    endfunction

    function automatic splice_step_t splice_push(chr_t w0, chr_t w1, logic [1:0] cnt, chr_t c);
        splice_step_t s;
        s.w0   = w0;
        s.w1   = w1;
        s.cnt  = cnt;
        s.emit = 1'b0;
        s.out  = c;
        if (!cnt[1])
        begin
            if (cnt == 2'd0)
                s.w0 = c;
            else
                s.w1 = c;
            s.cnt = cnt + 2'd1;
        end
        else if (w0.bytes[7:0] == BSLASH && w1.bytes[7:0] == NEWLINE)
        begin
            // backslash-newline dropped, the next character passes untested
            s.emit = 1'b1;
            s.out  = c;
            s.cnt  = 2'd0;
        end
        else
        begin
            s.emit = 1'b1;
            s.out  = w0;
            s.w0   = w1;
            s.w1   = c;
            s.cnt  = 2'd2;
        end
        return s;
    endfunction

endpackage

>>> rtl/tls_window.sv
// trigraph and splice lookahead windows, builds the result list for one item
// depends on tls_pkg

module tls_window
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      go,
    input  logic [31:0]               item_bytes,
    input  logic [2:0]                item_len,
    input  logic                      item_end,
    output tls_pkg::result_t          list [tls_pkg::MAX_RESULTS],
    output logic [tls_pkg::CNT_W-1:0] list_cnt
);

    tls_pkg::chr_t tw0_reg, tw0_next;
    tls_pkg::chr_t tw1_reg, tw1_next;
    tls_pkg::chr_t sw0_reg, sw0_next;
    tls_pkg::chr_t sw1_reg, sw1_next;
    logic [1:0]    tc_reg, tc_next;
    logic [1:0]    sc_reg, sc_next;

    always_comb
    begin
        tls_pkg::chr_t        c;
        tls_pkg::chr_t        r;
        tls_pkg::tri_hit_t    th;
        tls_pkg::splice_step_t st;
        tls_pkg::chr_t        w0;
        tls_pkg::chr_t        w1;
        logic [1:0]           cnt;
        logic [tls_pkg::CNT_W-1:0] n;

        tw0_next = tw0_reg;
        tw1_next = tw1_reg;
        sw0_next = sw0_reg;
        sw1_next = sw1_reg;
        tc_next  = tc_reg;
        sc_next  = sc_reg;
        for (int i = 0; i < tls_pkg::MAX_RESULTS; i++)
            list[i] = '0;
        n   = '0;
        c   = tls_pkg::norm_char(item_bytes, item_len);
        th  = tls_pkg::tri_map(c.bytes[7:0]);
        r   = '0;
        w0  = sw0_reg;
        w1  = sw1_reg;
        cnt = sc_reg;
        st  = tls_pkg::splice_push(sw0_reg, sw1_reg, sc_reg, tw0_reg);

        if (item_end)
        begin
            // flush stage one into stage two, untested for trigraphs
            if (tc_reg != 2'd0)
            begin
                st  = tls_pkg::splice_push(w0, w1, cnt, tw0_reg);
                w0  = st.w0;
                w1  = st.w1;
                cnt = st.cnt;
                if (st.emit)
                begin
                    list[n] = tls_pkg::mk_res(st.out, 1'b0, 1'b0);
                    n = n + tls_pkg::CNT_W'(1);
                end
            end
            if (tc_reg[1])
            begin
                st  = tls_pkg::splice_push(w0, w1, cnt, tw1_reg);
                w0  = st.w0;
                w1  = st.w1;
                cnt = st.cnt;
                if (st.emit)
                begin
                    list[n] = tls_pkg::mk_res(st.out, 1'b0, 1'b0);
                    n = n + tls_pkg::CNT_W'(1);
                end
            end
            if (cnt[1] && w0.bytes[7:0] == tls_pkg::BSLASH
                && w1.bytes[7:0] == tls_pkg::NEWLINE)
            begin
                list[n] = tls_pkg::mk_res('0, 1'b1, 1'b1);
                n = n + tls_pkg::CNT_W'(1);
            end
            else
            begin
                if (cnt != 2'd0)
                begin
                    list[n] = tls_pkg::mk_res(w0, 1'b0, 1'b0);
                    n = n + tls_pkg::CNT_W'(1);
                end
                if (cnt[1])
                begin
                    list[n] = tls_pkg::mk_res(w1, 1'b0, 1'b0);
                    n = n + tls_pkg::CNT_W'(1);
                end
                list[n] = tls_pkg::mk_res('0, 1'b1, 1'b0);
                n = n + tls_pkg::CNT_W'(1);
            end
            tc_next = 2'd0;
            sc_next = 2'd0;
        end
        else if (c.len != 3'd0)
        begin
            if (!tc_reg[1])
            begin
                if (tc_reg == 2'd0)
                    tw0_next = c;
                else
                    tw1_next = c;
                tc_next = tc_reg + 2'd1;
            end
            else
            begin
                if (tw0_reg.bytes[7:0] == tls_pkg::QMARK
                    && tw1_reg.bytes[7:0] == tls_pkg::QMARK && th.hit)
                begin
                    // replacement goes on and is never looked at again
                    r.bytes = {24'd0, th.to};
                    r.len   = 3'd1;
                    tc_next = 2'd0;
                    st = tls_pkg::splice_push(sw0_reg, sw1_reg, sc_reg, r);
                end
                else
                begin
                    tw0_next = tw1_reg;
                    tw1_next = c;
                    st = tls_pkg::splice_push(sw0_reg, sw1_reg, sc_reg, tw0_reg);
                end
                sw0_next = st.w0;
                sw1_next = st.w1;
                sc_next  = st.cnt;
                if (st.emit)
                begin
                    list[0] = tls_pkg::mk_res(st.out, 1'b0, 1'b0);
                    n = tls_pkg::CNT_W'(1);
                end
            end
        end
        list_cnt = n;
    end

    // window entries are only read below their counts
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            tw0_reg <= tw0_next;
            tw1_reg <= tw1_next;
            sw0_reg <= sw0_next;
            sw1_reg <= sw1_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg <= 2'd0;
            sc_reg <= 2'd0;
        end
        else if (go)
        begin
            tc_reg <= tc_next;
            sc_reg <= sc_next;
        end
    end

endmodule

>>> rtl/tls_result_buf.sv
// result register, a short shift queue holding the beats of one item
// depends on tls_pkg

module tls_result_buf
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  tls_pkg::result_t          list [tls_pkg::MAX_RESULTS],
    input  logic [tls_pkg::CNT_W-1:0] list_cnt,
    input  logic                      out_stall,
    output logic                      out_valid,
    output tls_pkg::result_t          head,
    output logic                      last,
    output logic                      drained
);

    tls_pkg::result_t          res_reg [tls_pkg::MAX_RESULTS];
    logic [tls_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      pop;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign last      = (cnt_reg == tls_pkg::CNT_W'(1));
    assign head      = res_reg[0];
    // empty now or after the beat being taken
    assign drained   = !out_valid || (pop && last);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
            cnt_next = list_cnt;
        else if (pop)
            cnt_next = cnt_reg - tls_pkg::CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < tls_pkg::MAX_RESULTS; i++)
                res_reg[i] <= list[i];
        end
        else if (pop)
        begin
            for (int i = 0; i < tls_pkg::MAX_RESULTS - 1; i++)
                res_reg[i] <= res_reg[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

endmodule

>>> rtl/trigraph_and_line_splice_core.sv
// top level of the trigraph replacement and line splice block
// depends on tls_pkg, tls_window and tls_result_buf
//
// usage
//   input channel: in_valid / in_stall carry one source character per beat
//   (char_bytes, char_len) or an end marker (end_of_input). a beat with
//   length zero and no end marker is dropped without a result.
//   output channel: out_valid / out_stall carry one result per beat, with
//   last marking the final beat caused by an input beat.
//   each character passes the input register, then the result register,
//   on its way to the first result beat.
//   throughput: one character per cycle while in_stall is low; a character
//   gives zero or one result beat. an end marker gives up to five beats
//   (flushed characters plus the end beat) and holds off the next input
//   while they drain. a stalled output keeps its beat; the next item waits
//   in the input register and in_stall rises until the result queue can be
//   refilled. reset clears the window counts and both registers; a new
//   stream may follow each end beat.

module trigraph_and_line_splice_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] char_bytes,
    input  logic [2:0]  char_len,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] out_bytes,
    output logic [2:0]  out_len,
    output logic        end_flag,
    output logic        error_flag,
    output logic        last
);

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [31:0] in_bytes_reg;
    logic [2:0]  in_len_reg;
    logic        in_end_reg;

    logic                      accept;
    logic                      go;
    logic                      drained;
    tls_pkg::result_t          list [tls_pkg::MAX_RESULTS];
    logic [tls_pkg::CNT_W-1:0] list_cnt;
    tls_pkg::result_t          head;

    // an item is worked on once the result queue empties this cycle
    assign go       = in_valid_reg && drained;
    assign in_stall = in_valid_reg && !drained;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (go)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_bytes_reg <= char_bytes;
            in_len_reg   <= char_len;
            in_end_reg   <= end_of_input;
        end
    end

    // both lookahead windows and the result list for the held item
    tls_window u_window
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .item_bytes (in_bytes_reg),
        .item_len   (in_len_reg),
        .item_end   (in_end_reg),
        .list       (list),
        .list_cnt   (list_cnt)
    );

    // result queue feeding the output channel
    tls_result_buf u_result_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (go),
        .list      (list),
        .list_cnt  (list_cnt),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .head      (head),
        .last      (last),
        .drained   (drained)
    );

    assign out_bytes  = head.chr.bytes;
    assign out_len    = head.chr.len;
    assign end_flag   = head.end_f;
    assign error_flag = head.err_f;

    // the end beat always closes its item
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_flag) |-> last)
        else $error("end beat not marked last");

    // only end beats carry no bytes
    a_len_vs_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_len == 3'd0) == end_flag))
        else $error("output length disagrees with end flag");

    // error is only reported on an end beat
    a_err_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error_flag) |-> end_flag)
        else $error("error flag outside end beat");

    // a held item is taken as soon as the queue drains
    a_item_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid) |=> (!in_valid_reg || $past(accept)))
        else $error("held item not consumed with empty result queue");

endmodule
